// ----- hdl/rpcc_pkg.sv -----
// Shared constants, types and CRC byte-step functions for the packet CRC checker.
package rpcc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ShortW   = 14;
  localparam int unsigned LongW    = 16;
  localparam int unsigned CountW   = 4;
  localparam int unsigned SeedW    = 16;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 40;

  localparam logic [ShortW-1:0] ShortPoly = 14'h2E57;
  localparam logic [LongW-1:0]  LongPoly  = 16'h3D65;

  // Byte positions inside a packet
  localparam logic [CountW-1:0] IdxFirst   = 4'd0;
  localparam logic [CountW-1:0] IdxShortEnd = 4'd7;   // last byte of an 8-byte packet
  localparam logic [CountW-1:0] IdxEleven  = 4'd11;
  localparam logic [CountW-1:0] IdxLongEnd = 4'd12;   // last byte of a 13-byte packet
  localparam logic [CountW-1:0] IdxMax     = 4'd15;

  typedef enum logic [1:0] {
    PKT_NORMAL0  = 2'd0,
    PKT_NORMAL1  = 2'd1,
    PKT_SYNC     = 2'd2,
    PKT_RESERVED = 2'd3
  } pkt_type_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEN  = 2'd1,
    ST_BAD_TYPE = 2'd2,
    ST_CRC_ERR  = 2'd3
  } status_e;

  typedef struct packed {
    logic [LongW-1:0]  computed_crc;
    logic [LongW-1:0]  received_crc;
    logic [1:0]        packet_type;
    status_e           status;
    logic              valid_res;
  } result_t;

  // One byte of the 14-bit CRC, MSB first
  function automatic logic [ShortW-1:0] crc14_byte(logic [ShortW-1:0] crc,
                                                   logic [ByteW-1:0] b);
    logic [ShortW-1:0] c;
    c = crc ^ {b, {(ShortW-ByteW){1'b0}}};
    for (int k = 0; k < ByteW; k++) begin
      c = c[ShortW-1] ? ({c[ShortW-2:0], 1'b0} ^ ShortPoly) : {c[ShortW-2:0], 1'b0};
    end
    return c;
  endfunction

  // One byte of the 16-bit CRC, MSB first
  function automatic logic [LongW-1:0] crc16_byte(logic [LongW-1:0] crc,
                                                  logic [ByteW-1:0] b);
    logic [LongW-1:0] c;
    c = crc ^ {b, {(LongW-ByteW){1'b0}}};
    for (int k = 0; k < ByteW; k++) begin
      c = c[LongW-1] ? ({c[LongW-2:0], 1'b0} ^ LongPoly) : {c[LongW-2:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- hdl/rpcc_crc_update.sv -----
// Next-value logic for the two running CRCs, including the per-packet seeding.
module rpcc_crc_update (
  input  logic [rpcc_pkg::CountW-1:0] idx_i,
  input  logic [rpcc_pkg::ByteW-1:0]  data_i,
  input  logic [rpcc_pkg::ByteW-1:0]  nonce_i,
  input  logic [rpcc_pkg::SeedW-1:0]  seed_i,
  input  logic [rpcc_pkg::ShortW-1:0] crc_short_i,
  input  logic [rpcc_pkg::LongW-1:0]  crc_long_i,
  output logic [rpcc_pkg::ShortW-1:0] crc_short_o,
  output logic [rpcc_pkg::LongW-1:0]  crc_long_o
);
  import rpcc_pkg::*;

  logic              first;
  logic [SeedW-1:0]  init;
  logic [ShortW-1:0] short_base;
  logic [LongW-1:0]  long_base;
  logic [ByteW-1:0]  short_byte;

  assign first = (idx_i == IdxFirst);
  // sync packets are seeded without the nonce
  assign init  = (data_i[1:0] == PKT_SYNC) ? seed_i
                                           : (seed_i ^ {{(SeedW-ByteW){1'b0}}, nonce_i});

  assign short_base = first ? init[ShortW-1:0] : crc_short_i;
  assign long_base  = first ? init : crc_long_i;
  // only the type bits of byte zero are covered by the short CRC
  assign short_byte = first ? {{(ByteW-2){1'b0}}, data_i[1:0]} : data_i;

  assign crc_short_o = (idx_i < IdxShortEnd) ? crc14_byte(short_base, short_byte)
                                             : crc_short_i;
  assign crc_long_o  = (idx_i < IdxEleven) ? crc16_byte(long_base, data_i) : crc_long_i;

endmodule

// ----- hdl/radio_packet_crc_check_unit.sv -----
// Top level: streaming packet validator with 14-bit and 16-bit CRC checks.
// Flow: each byte is registered at the input and processed when it advances; a closing
//   byte advances only while the result register is free, and its verdict lands there.
// Throughput: one byte per cycle, save a closing byte held by a stalled result; the input
//   and result registers decouple the two sides; other bytes pass even while it is stalled.
// Reset (rst_ni low, asynchronous): byte count, CRCs, captured bytes, seed and all valid
//   flags go to zero; the next byte taken is byte zero of a new packet.
module radio_packet_crc_check_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration: CRC seed
  input  logic                          cfg_we_i,
  input  logic [rpcc_pkg::SeedW-1:0]    cfg_wdata_i,
  // byte stream in
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [rpcc_pkg::InDataW-1:0]  s_axis_tdata_i,   // [7:0] data_byte, [15:8] nonce
  input  logic                          s_axis_tlast_i,   // last_byte
  // verdict out
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [0] valid_res, [2:1] status, [4:3] packet_type, [20:5] received_crc,
  // [36:21] computed_crc, [39:37] zero
  output logic [rpcc_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import rpcc_pkg::*;

  // ---------------------------------------------------------------- config
  logic [SeedW-1:0] seed_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------- input register
  logic             in_vld_q;
  logic [ByteW-1:0] in_data_q;
  logic [ByteW-1:0] in_nonce_q;
  logic             in_last_q;
  logic             advance;
  logic             out_vld_q;

  // A byte that closes no packet never needs the result register, so it moves on
  // regardless of the downstream stall.
  assign advance         = in_vld_q && (!in_last_q || !out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q  <= s_axis_tdata_i[ByteW-1:0];
      in_nonce_q <= s_axis_tdata_i[InDataW-1:ByteW];
      in_last_q  <= s_axis_tlast_i;
    end
  end

  // ---------------------------------------------------------------- packet state
  logic [CountW-1:0] count_q, count_d;
  logic [ShortW-1:0] crc_short_q, crc_short_d;
  logic [LongW-1:0]  crc_long_q, crc_long_d;
  logic [ByteW-1:0]  first_byte_q, first_byte_d;
  logic [ByteW-1:0]  byte_seven_q, byte_seven_d;
  logic [ByteW-1:0]  byte_eleven_q, byte_eleven_d;

  rpcc_crc_update u_crc (
    .idx_i       (count_q),
    .data_i      (in_data_q),
    .nonce_i     (in_nonce_q),
    .seed_i      (seed_q),
    .crc_short_i (crc_short_q),
    .crc_long_i  (crc_long_q),
    .crc_short_o (crc_short_d),
    .crc_long_o  (crc_long_d)
  );

  assign first_byte_d  = (count_q == IdxFirst)    ? in_data_q : first_byte_q;
  assign byte_seven_d  = (count_q == IdxShortEnd) ? in_data_q : byte_seven_q;
  assign byte_eleven_d = (count_q == IdxEleven)   ? in_data_q : byte_eleven_q;

  always_comb begin
    if (in_last_q) begin
      count_d = '0;
    end else if (count_q == IdxMax) begin
      count_d = IdxMax;              // saturate: overlong packets stay bad length
    end else begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      crc_short_q   <= '0;
      crc_long_q    <= '0;
      first_byte_q  <= '0;
      byte_seven_q  <= '0;
      byte_eleven_q <= '0;
    end else if (advance) begin
      count_q       <= count_d;
      crc_short_q   <= crc_short_d;
      crc_long_q    <= crc_long_d;
      first_byte_q  <= first_byte_d;
      byte_seven_q  <= byte_seven_d;
      byte_eleven_q <= byte_eleven_d;
    end
  end

  // ---------------------------------------------------------------- verdict
  result_t res_d, res_q;

  always_comb begin
    res_d              = '0;
    res_d.packet_type  = first_byte_d[1:0];
    if (count_q != IdxShortEnd && count_q != IdxLongEnd) begin
      res_d.status = ST_BAD_LEN;
    end else if (first_byte_d[1:0] == PKT_RESERVED) begin
      res_d.status = ST_BAD_TYPE;      // length is judged before type
    end else begin
      if (count_q == IdxShortEnd) begin
        // byte zero's upper six bits carry the high part of the short CRC
        res_d.received_crc = {2'b00, first_byte_d[ByteW-1:2], in_data_q};
        res_d.computed_crc = {2'b00, crc_short_q};
      end else begin
        res_d.received_crc = {in_data_q, byte_eleven_q};
        res_d.computed_crc = crc_long_q;
      end
      res_d.status = (res_d.received_crc == res_d.computed_crc) ? ST_OK : ST_CRC_ERR;
    end
    res_d.valid_res = (res_d.status == ST_OK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OutDataW-$bits(result_t)){1'b0}}, res_q};

  // ---------------------------------------------------------------- checks
  // a result is never overwritten while it waits to be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready_i && advance) |-> !in_last_q)
    else $error("pending result overwritten");

  // the packet byte counter restarts after a closing byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_last_q) |=> (count_q == IdxFirst))
    else $error("byte count not cleared after last byte");

  // a pass verdict means both CRC fields agree; length/type failures report no CRCs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.valid_res) |-> (res_q.received_crc == res_q.computed_crc))
    else $error("valid verdict with CRC mismatch");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (res_q.status == ST_BAD_LEN || res_q.status == ST_BAD_TYPE))
      |-> (res_q.received_crc == '0 && res_q.computed_crc == '0 && !res_q.valid_res))
    else $error("rejected packet carries CRC fields");

endmodule

// ----- verif/radio_packet_crc_check_unit_test.sv -----
// Self-checking testbench for the radio packet CRC checker: directed packets and random packet streams, scoreboard.
module radio_packet_crc_check_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rpcc_pkg::*;

  // Run bounds
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 300;   // one long back-pressure stretch on the verdicts
  localparam int unsigned MaxLen     = 20;    // longest packet we ever build
  localparam int unsigned PhaseBytes = 280;   // random bytes per seed setting

  // One byte request on the input stream
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic [7:0] nonce;
  } byte_req_t;

  logic                clk_i = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [SeedW-1:0]    cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  in_data = '0;       // [7:0] data_byte, [15:8] nonce
  logic                in_last = 1'b0;     // last_byte
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [OutDataW-1:0] out_data;           // [0] valid_res, [2:1] status, [4:3] packet_type,
                                           // [20:5] received_crc, [36:21] computed_crc

  radio_packet_crc_check_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tlast_i  (in_last),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Pending byte requests, filled by the stimulus block and drained by the driver
  byte_req_t pending_bytes [$];
  // Verdicts the block owes us, oldest first
  result_t   verdicts_due [$];

  int unsigned n_queued = 0;
  int unsigned n_taken = 0;
  int unsigned n_verdicts = 0;
  int unsigned n_faults = 0;
  int unsigned n_seeds = 0;
  int unsigned n_cycles = 0;
  int unsigned n_by_status [4] = '{0, 0, 0, 0};
  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 33;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  // Our own view of the block: seed, byte position, running CRCs and captured bytes
  logic [SeedW-1:0]  link_seed = '0;
  logic [CountW-1:0] pos_q = '0;
  logic [ShortW-1:0] crc14_q = '0;
  logic [LongW-1:0]  crc16_q = '0;
  logic [7:0]        head_byte_q = '0;
  logic [7:0]        byte7_q = '0;
  logic [7:0]        byte11_q = '0;

  // Bit-serial forms of the two CRCs, MSB of the byte first
  function automatic logic [ShortW-1:0] crc14_step(logic [ShortW-1:0] c, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[ShortW-1] ^ b[i];
      c  = {c[ShortW-2:0], 1'b0};
      if (fb) c = c ^ ShortPoly;
    end
    return c;
  endfunction

  function automatic logic [LongW-1:0] crc16_step(logic [LongW-1:0] c, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[LongW-1] ^ b[i];
      c  = {c[LongW-2:0], 1'b0};
      if (fb) c = c ^ LongPoly;
    end
    return c;
  endfunction

  // Advance the packet tracker by one accepted byte; a last byte yields one verdict.
  task automatic track_packet_byte(input logic [7:0] b, input logic last,
                                   input logic [7:0] nonce);
    logic [LongW-1:0] init;
    result_t          v;
    if (pos_q == IdxFirst) begin
      head_byte_q = b;
      // sync packets ignore the nonce
      init    = link_seed ^ ((b[1:0] == PKT_SYNC) ? 16'h0000 : {8'h00, nonce});
      crc14_q = init[ShortW-1:0];
      crc16_q = init;
    end
    // short CRC sees only the type bits of byte zero
    if (pos_q < IdxShortEnd)
      crc14_q = crc14_step(crc14_q, (pos_q == IdxFirst) ? {6'b0, b[1:0]} : b);
    if (pos_q < IdxEleven) crc16_q = crc16_step(crc16_q, b);
    if (pos_q == IdxShortEnd) byte7_q = b;
    if (pos_q == IdxEleven) byte11_q = b;
    if (!last) begin
      if (pos_q != IdxMax) pos_q = pos_q + 1'b1;   // saturates on runaway packets
      return;
    end
    v = '0;
    v.packet_type = head_byte_q[1:0];
    // length first, then type, then the CRC itself
    if (pos_q != IdxShortEnd && pos_q != IdxLongEnd) begin
      v.status = ST_BAD_LEN;
    end else if (head_byte_q[1:0] == PKT_RESERVED) begin
      v.status = ST_BAD_TYPE;
    end else begin
      if (pos_q == IdxShortEnd) begin
        v.received_crc = {2'b00, head_byte_q[7:2], byte7_q};
        v.computed_crc = {2'b00, crc14_q};
      end else begin
        v.received_crc = {b, byte11_q};
        v.computed_crc = crc16_q;
      end
      v.status    = (v.received_crc == v.computed_crc) ? ST_OK : ST_CRC_ERR;
      v.valid_res = (v.status == ST_OK);
    end
    verdicts_due.push_back(v);
    pos_q = '0;
  endtask

  // Build one packet; seal fills in a correct CRC for 8 and 13 byte packets, spoil
  // then flips one bit somewhere after byte zero.
  task automatic queue_packet(input int len, input pkt_type_e kind, input bit seal,
                              input bit spoil);
    logic [7:0]        body [MaxLen];
    logic [7:0]        head_nonce;
    logic [LongW-1:0]  init;
    logic [ShortW-1:0] c14;
    logic [LongW-1:0]  c16;
    int                flip;
    byte_req_t         r;
    head_nonce = 8'($urandom);
    for (int i = 0; i < len; i++) body[i] = 8'($urandom);
    body[0][1:0] = kind;
    if (seal && (len == 8 || len == 13)) begin
      init = link_seed ^ ((kind == PKT_SYNC) ? 16'h0000 : {8'h00, head_nonce});
      c14  = init[ShortW-1:0];
      c16  = init;
      if (len == 8) begin
        c14 = crc14_step(c14, {6'b0, kind});
        for (int i = 1; i < 7; i++) c14 = crc14_step(c14, body[i]);
        body[0][7:2] = c14[13:8];
        body[7]      = c14[7:0];
      end else begin
        for (int i = 0; i < 11; i++) c16 = crc16_step(c16, body[i]);
        body[11] = c16[7:0];
        body[12] = c16[15:8];
      end
    end
    if (spoil && len > 1) begin
      flip       = $urandom_range(len - 1, 1);
      body[flip] = body[flip] ^ (8'h01 << $urandom_range(7));
    end
    for (int i = 0; i < len; i++) begin
      r.data  = body[i];
      r.last  = (i == len - 1);
      r.nonce = (i == 0) ? head_nonce : 8'($urandom);   // nonce on later bytes is noise
      pending_bytes.push_back(r);
      n_queued++;
    end
  endtask

  // Mostly well-formed packets with random content; the rest odd lengths and runaways.
  task automatic queue_random_traffic(input int unsigned n_bytes);
    int unsigned start;
    int unsigned pick;
    start = n_queued;
    while (n_queued - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 70)
        queue_packet($urandom_range(1) ? 13 : 8, pkt_type_e'($urandom_range(3)), 1'b1,
                     $urandom_range(4) == 0);
      else if (pick < 85)
        queue_packet($urandom_range(MaxLen, 1), pkt_type_e'($urandom_range(3)), 1'b0, 1'b0);
      else
        queue_packet($urandom_range(1) ? ($urandom_range(1) ? 7 : 9)
                                       : ($urandom_range(1) ? 12 : 14),
                     pkt_type_e'($urandom_range(3)), 1'b0, 1'b0);
    end
  endtask

  // Seed write: only ever called with the block idle
  task automatic load_seed(input logic [SeedW-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    link_seed = value;
    n_seeds++;
  endtask

  // Wait for every byte to be taken and every verdict to come back.
  task automatic settle();
    while (n_taken != n_queued || verdicts_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Driver: offers the next pending byte request, with random gaps between requests.
  always @(posedge clk_i) begin
    byte_req_t nxt;
    if (rst_n) begin
      if (in_valid && s_axis_tready) begin
        track_packet_byte(in_data[7:0], in_last, in_data[15:8]);
        n_taken++;
      end
      if (!in_valid || s_axis_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_data  <= {nxt.nonce, nxt.data};
          in_last  <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes verdicts, checks them field by field, and throttles tready.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = out_data[36:0];
        if (verdicts_due.size() == 0) begin
          $error("verdict with none outstanding: tdata %h", out_data);
          n_faults++;
        end else begin
          want = verdicts_due.pop_front();
          n_verdicts++;
          n_by_status[want.status]++;
          if (got.valid_res !== want.valid_res) begin
            $error("valid_res: expected %0d, got %0d", want.valid_res, got.valid_res);
            n_faults++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            n_faults++;
          end
          if (got.packet_type !== want.packet_type) begin
            $error("packet_type: expected %0d, got %0d", want.packet_type, got.packet_type);
            n_faults++;
          end
          if (got.received_crc !== want.received_crc) begin
            $error("received_crc: expected %h, got %h", want.received_crc,
                   got.received_crc);
            n_faults++;
          end
          if (got.computed_crc !== want.computed_crc) begin
            $error("computed_crc: expected %h, got %h", want.computed_crc,
                   got.computed_crc);
            n_faults++;
          end
          if (out_data[OutDataW-1:37] !== '0) begin
            $error("tdata padding: expected 0, got %h", out_data[OutDataW-1:37]);
            n_faults++;
          end
        end
      end
      // one long hold-off so the result stage backs up into the input
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && n_verdicts >= 40) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    byte_req_t r;
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed: tiny runt with all-ones fields, a good short packet, a good long sync
    // packet (nonce ignored), reserved type at a valid length, a CRC error, a runaway
    // packet past the counter's saturation, and a spoilt sync packet.
    load_seed(16'h0000);
    r.data  = 8'hFF;
    r.last  = 1'b1;
    r.nonce = 8'hFF;
    pending_bytes.push_back(r);
    n_queued++;
    queue_packet(8, PKT_NORMAL0, 1'b1, 1'b0);
    queue_packet(13, PKT_SYNC, 1'b1, 1'b0);
    queue_packet(8, PKT_RESERVED, 1'b1, 1'b0);
    queue_packet(13, PKT_NORMAL1, 1'b1, 1'b1);
    queue_packet(17, PKT_NORMAL1, 1'b0, 1'b0);
    queue_packet(8, PKT_SYNC, 1'b1, 1'b1);
    settle();

    // Random phases over a spread of seeds, extremes included
    load_seed(16'hFFFF);
    queue_random_traffic(PhaseBytes);
    settle();

    send_idle_pct = 0;   // a stretch with both sides running flat out
    recv_idle_pct = 0;
    load_seed(16'($urandom));
    queue_random_traffic(PhaseBytes);
    settle();

    send_idle_pct = 33;
    recv_idle_pct = 33;
    load_seed(16'h8001);
    queue_random_traffic(PhaseBytes);
    settle();

    load_seed(16'($urandom));
    queue_random_traffic(PhaseBytes);
    settle();

    load_seed(16'h0000);
    queue_random_traffic(PhaseBytes);
    settle();

    $display("covered %0d byte requests and %0d verdicts over %0d seed settings",
             n_taken, n_verdicts, n_seeds);
    $display("verdicts: ok %0d, bad length %0d, bad type %0d, crc error %0d",
             n_by_status[ST_OK], n_by_status[ST_BAD_LEN], n_by_status[ST_BAD_TYPE],
             n_by_status[ST_CRC_ERR]);
    if (n_faults == 0 && verdicts_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
